// ===== design/dfpe_pkg.sv =====
// Shared constants, stage codes and result type for the display frame payload extractor.
package dfpe_pkg;

    localparam logic [7:0]  HEADER_FIRST    = 8'h5A;
    localparam logic [7:0]  HEADER_SECOND   = 8'hA5;
    localparam logic [7:0]  MIN_LENGTH      = 8'd4;
    localparam logic [7:0]  OVERHEAD        = 8'd3;
    localparam logic [15:0] WATCHED_ADDR_RST = {8'h30, 8'h09};

    localparam int unsigned STAGE_W = 3;

    localparam logic [STAGE_W-1:0] ST_HUNT    = 3'd0;
    localparam logic [STAGE_W-1:0] ST_HDR2    = 3'd1;
    localparam logic [STAGE_W-1:0] ST_LENGTH  = 3'd2;
    localparam logic [STAGE_W-1:0] ST_COMMAND = 3'd3;
    localparam logic [STAGE_W-1:0] ST_ADDR_HI = 3'd4;
    localparam logic [STAGE_W-1:0] ST_ADDR_LO = 3'd5;
    localparam logic [STAGE_W-1:0] ST_PAYLOAD = 3'd6;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic       last_of_frame;
        logic       length_error;
    } t_result;

endpackage

// ===== design/dfpe_if.sv =====
// Handshake channel interfaces for received bytes and extracted payload results.
interface dfpe_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfpe_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic       last_of_frame;
    logic       length_error;

    modport source (output valid, output payload_byte, output byte_index,
                    output last_of_frame, output length_error, input ready);
    modport sink   (input valid, input payload_byte, input byte_index,
                    input last_of_frame, input length_error, output ready);
endinterface

// ===== design/display_frame_payload_extractor_unit.sv =====
// Top level: input byte register, frame parser and result register.
// Each byte passes through the input byte register and the frame parser; its result, if any,
// is presented from the result register, which loads only when the result channel is free.
// Throughput: one byte per cycle while the result channel is not stalled; the stage update sets the rate.
// A byte that yields no result never waits on the result channel.
// Synchronous active-low reset clears stage, counters, valids; address -> 0x3009.
module display_frame_payload_extractor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    dfpe_rx_if.sink     i_rx,
    dfpe_res_if.source  o_res
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              has_result;
    logic              out_free;
    logic              advance;
    dfpe_pkg::t_result result;

    assign advance    = r_in_valid && (!has_result || out_free);
    assign i_rx.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    dfpe_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (advance),
        .i_byte        (r_in_byte),
        .o_has_result  (has_result),
        .o_result      (result)
    );

    dfpe_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (result),
        .o_free   (out_free),
        .o_res    (o_res)
    );

endmodule

// ===== design/dfpe_parser.sv =====
// Frame parser: stage register, counters, address register and result forming.
module dfpe_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [15:0]          i_cfg_wr_data,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output logic                 o_has_result,
    output dfpe_pkg::t_result    o_result
);

    logic [dfpe_pkg::STAGE_W-1:0] r_stage, n_stage;
    logic [7:0]                   r_remaining, n_remaining;
    logic [7:0]                   r_position, n_position;
    logic [15:0]                  r_watched;

    always_comb begin
        n_stage      = dfpe_pkg::ST_HUNT;
        n_remaining  = r_remaining;
        n_position   = r_position;
        o_has_result = 1'b0;
        o_result     = '0;
        unique case (r_stage)
            dfpe_pkg::ST_HUNT: begin
                if (i_byte == dfpe_pkg::HEADER_FIRST) n_stage = dfpe_pkg::ST_HDR2;
            end
            dfpe_pkg::ST_HDR2: begin
                if (i_byte == dfpe_pkg::HEADER_SECOND) n_stage = dfpe_pkg::ST_LENGTH;
            end
            dfpe_pkg::ST_LENGTH: begin
                if (i_byte < dfpe_pkg::MIN_LENGTH) begin
                    o_has_result          = 1'b1;
                    o_result.length_error = 1'b1;
                end else begin
                    n_remaining = i_byte - dfpe_pkg::OVERHEAD;
                    n_stage     = dfpe_pkg::ST_COMMAND;
                end
            end
            dfpe_pkg::ST_COMMAND: begin
                n_stage = dfpe_pkg::ST_ADDR_HI;
            end
            dfpe_pkg::ST_ADDR_HI: begin
                if (i_byte == r_watched[15:8]) n_stage = dfpe_pkg::ST_ADDR_LO;
            end
            dfpe_pkg::ST_ADDR_LO: begin
                if (i_byte == r_watched[7:0]) begin
                    n_stage    = dfpe_pkg::ST_PAYLOAD;
                    n_position = '0;
                end
            end
            dfpe_pkg::ST_PAYLOAD: begin
                o_has_result           = 1'b1;
                o_result.payload_byte  = i_byte;
                o_result.byte_index    = r_position;
                o_result.last_of_frame = (r_remaining <= 8'd1);
                n_position             = r_position + 8'd1;
                if (r_remaining <= 8'd1) begin
                    n_remaining = '0;
                end else begin
                    n_remaining = r_remaining - 8'd1;
                    n_stage     = dfpe_pkg::ST_PAYLOAD;
                end
            end
            default: begin
                n_stage = dfpe_pkg::ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= dfpe_pkg::ST_HUNT;
            r_remaining <= '0;
            r_position  <= '0;
            r_watched   <= dfpe_pkg::WATCHED_ADDR_RST;
        end else begin
            if (i_cfg_wr_en) begin
                r_watched <= i_cfg_wr_data;
            end
            if (i_step) begin
                r_stage     <= n_stage;
                r_remaining <= n_remaining;
                r_position  <= n_position;
            end
        end
    end

endmodule

// ===== design/dfpe_out_stage.sv =====
// Result register driving the result channel.
module dfpe_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  dfpe_pkg::t_result  i_result,
    output logic               o_free,
    dfpe_res_if.source         o_res
);

    logic              r_valid;
    dfpe_pkg::t_result r_result;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.payload_byte  = r_result.payload_byte;
    assign o_res.byte_index    = r_result.byte_index;
    assign o_res.last_of_frame = r_result.last_of_frame;
    assign o_res.length_error  = r_result.length_error;

endmodule
